// ===== hdl/crf_pkg.sv =====
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types, constants and the byte-wide CRC-32 update for the frame
// command responder.
// ----------------------------------------------------------------------------
`default_nettype none

package crf_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam logic [7:0] CMD_START = 8'h01;
   localparam logic [7:0] CMD_DATA  = 8'h02;
   localparam logic [7:0] ACK_START = 8'h81;
   localparam logic [7:0] ACK_DATA  = 8'h82;

   localparam logic [7:0] STATUS_GOOD = 8'h01;
   localparam logic [7:0] STATUS_BAD  = 8'h02;

   localparam int HDR_BYTES   = 8;
   localparam int ARG_BYTES   = 6;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [3:0] POS_SAT       = 4'd8;
   localparam logic [3:0] POS_CRC_START = 4'd4;
   localparam logic [3:0] POS_MIN_GOOD  = 4'd5;

   localparam logic [3:0] START_PAYLOAD = 4'd8;
   localparam logic [3:0] DATA_PAYLOAD  = 4'd5;
   localparam logic [3:0] START_LAST    = 4'd11;
   localparam logic [3:0] DATA_LAST     = 4'd8;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic                          is_start;
      logic [ARG_BYTES-1:0][7:0]     args;
      logic                          good;
      logic                          started;
      logic                          done;
   } reply_desc_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/crf_channels.sv =====
// ----------------------------------------------------------------------------
// crf channels
// Valid/ready channel interfaces for received bytes, reply bytes and the
// family register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface crf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface crf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_last;
   logic       update_started;
   logic       update_done;

   modport source (output valid, output tx_byte, output tx_last, output update_started,
                   output update_done, input ready);
   modport sink   (input valid, input tx_byte, input tx_last, input update_started,
                   input update_done, output ready);
endinterface

interface crf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] family_id;

   modport source (output valid, output family_id, input ready);
   modport sink   (input valid, input family_id, output ready);
endinterface

`default_nettype wire

// ===== hdl/crf_queue.sv =====
// ----------------------------------------------------------------------------
// crf_queue
// Small show-ahead FIFO of reply descriptors between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_queue #(
   parameter int DEPTH = crf_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  crf_pkg::reply_desc_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output crf_pkg::reply_desc_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   crf_pkg::reply_desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/crf_front.sv =====
// ----------------------------------------------------------------------------
// crf_front
// Takes one request byte per cycle while the queue has room, keeps the header,
// trailer window and running CRC; queues a reply per good start or data frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              rx_byte,
   input  logic                    frame_end,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_family,
   output logic [7:0]              family,
   input  logic                    queue_full,
   output logic                    push,
   output crf_pkg::reply_desc_type push_data
);

   logic [3:0]  pos_ff, pos_in, pos_upd;
   crf_pkg::byte_type hdr_ff [crf_pkg::HDR_BYTES];
   crf_pkg::byte_type hdr_in [crf_pkg::HDR_BYTES];
   crf_pkg::byte_type hdr_upd [crf_pkg::HDR_BYTES];
   logic [31:0] win_ff, win_in, win_upd;
   logic [31:0] crc_ff, crc_in, crc_upd;
   logic [15:0] ptotal_ff, ptotal_in;
   logic        started_ff, started_in;
   logic        done_ff, done_in;
   logic [7:0]  family_ff, family_in;

   logic        accept, good, is_start, is_data, last_pkg;
   logic [15:0] pkg_idx;

   assign req_ready = !queue_full;
   assign csr_ready = 1'b1;
   assign family    = family_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      crc_upd = (pos_ff >= crf_pkg::POS_CRC_START) ? crf_pkg::crc_byte(crc_ff, win_ff[31:24])
                                                   : crc_ff;
      win_upd = {win_ff[23:0], rx_byte};
      pos_upd = (pos_ff == crf_pkg::POS_SAT) ? pos_ff : pos_ff + 4'd1;
      for (int i = 0; i < crf_pkg::HDR_BYTES; i++) begin
         hdr_upd[i] = (!pos_ff[3] && (pos_ff[2:0] == 3'(i))) ? rx_byte : hdr_ff[i];
      end

      good     = (pos_upd >= crf_pkg::POS_MIN_GOOD) && ((crc_upd ^ crf_pkg::CRC_ONES) == win_upd);
      is_start = (hdr_upd[0] == family_ff) && (hdr_upd[1] == crf_pkg::CMD_START);
      is_data  = (hdr_upd[0] == family_ff) && (hdr_upd[1] == crf_pkg::CMD_DATA);
      pkg_idx  = {hdr_upd[2], hdr_upd[3]};
      last_pkg = (ptotal_ff != 16'd0) && (pkg_idx == ptotal_ff - 16'd1);

      pos_in     = pos_ff;
      win_in     = win_ff;
      crc_in     = crc_ff;
      ptotal_in  = ptotal_ff;
      started_in = started_ff;
      done_in    = done_ff;
      family_in  = csr_valid ? csr_family : family_ff;
      for (int i = 0; i < crf_pkg::HDR_BYTES; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      push = 1'b0;

      if (accept) begin
         if (!frame_end) begin
            pos_in = pos_upd;
            win_in = win_upd;
            crc_in = crc_upd;
            for (int i = 0; i < crf_pkg::HDR_BYTES; i++) begin
               hdr_in[i] = hdr_upd[i];
            end
         end else begin
            pos_in = '0;
            win_in = '0;
            crc_in = crf_pkg::CRC_ONES;
            for (int i = 0; i < crf_pkg::HDR_BYTES; i++) begin
               hdr_in[i] = '0;
            end
            if (is_start && good) begin
               started_in = 1'b1;
               ptotal_in  = {hdr_upd[6], hdr_upd[7]};
               push       = 1'b1;
            end else if (is_data) begin
               if (good && last_pkg) begin
                  done_in = 1'b1;
               end
               push = 1'b1;
            end
         end
      end

      push_data.is_start = is_start;
      for (int i = 0; i < crf_pkg::ARG_BYTES; i++) begin
         push_data.args[i] = hdr_upd[i + 2];
      end
      push_data.good    = good;
      push_data.started = started_in;
      push_data.done    = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         win_ff     <= '0;
         crc_ff     <= crf_pkg::CRC_ONES;
         ptotal_ff  <= '0;
         started_ff <= 1'b0;
         done_ff    <= 1'b0;
         family_ff  <= '0;
         for (int i = 0; i < crf_pkg::HDR_BYTES; i++) begin
            hdr_ff[i] <= '0;
         end
      end else begin
         pos_ff     <= pos_in;
         win_ff     <= win_in;
         crc_ff     <= crc_in;
         ptotal_ff  <= ptotal_in;
         started_ff <= started_in;
         done_ff    <= done_in;
         family_ff  <= family_in;
         for (int i = 0; i < crf_pkg::HDR_BYTES; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/crf_back.sv =====
// ----------------------------------------------------------------------------
// crf_back
// Streams one reply per descriptor, byte by byte, and appends the CRC-32 of
// the reply body, computed as the body bytes are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              family,
   input  logic                    head_valid,
   input  crf_pkg::reply_desc_type head_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              tx_byte,
   output logic                    tx_last,
   output logic                    update_started,
   output logic                    update_done
);

   logic                    busy_ff, busy_in;
   crf_pkg::reply_desc_type desc_ff, desc_in;
   logic [3:0]              idx_ff, idx_in;
   logic [31:0]             crc_ff, crc_in;

   logic [3:0]  n_pay, last_idx, crc_sel;
   logic [31:0] crc_out;
   logic [7:0]  pay_byte, crc_part;
   logic        in_crc, fire, reply_end;

   always_comb begin
      n_pay    = desc_ff.is_start ? crf_pkg::START_PAYLOAD : crf_pkg::DATA_PAYLOAD;
      last_idx = desc_ff.is_start ? crf_pkg::START_LAST : crf_pkg::DATA_LAST;
      in_crc   = (idx_ff >= n_pay);
      crc_out  = crc_ff ^ crf_pkg::CRC_ONES;
      crc_sel  = idx_ff - n_pay;

      case (idx_ff)
         4'd0:    pay_byte = family;
         4'd1:    pay_byte = desc_ff.is_start ? crf_pkg::ACK_START : crf_pkg::ACK_DATA;
         4'd2:    pay_byte = desc_ff.args[0];
         4'd3:    pay_byte = desc_ff.args[1];
         4'd4: begin
            if (desc_ff.is_start) begin
               pay_byte = desc_ff.args[2];
            end else begin
               pay_byte = desc_ff.good ? crf_pkg::STATUS_GOOD : crf_pkg::STATUS_BAD;
            end
         end
         4'd5:    pay_byte = desc_ff.args[3];
         4'd6:    pay_byte = desc_ff.args[4];
         4'd7:    pay_byte = desc_ff.args[5];
         default: pay_byte = '0;
      endcase

      case (crc_sel[1:0])
         2'd0:    crc_part = crc_out[31:24];
         2'd1:    crc_part = crc_out[23:16];
         2'd2:    crc_part = crc_out[15:8];
         default: crc_part = crc_out[7:0];
      endcase

      tx_byte        = in_crc ? crc_part : pay_byte;
      tx_last        = (idx_ff == last_idx);
      update_started = desc_ff.started;
      update_done    = desc_ff.done;
      rsp_valid      = busy_ff;

      fire      = busy_ff && rsp_ready;
      reply_end = fire && tx_last;
      pop       = head_valid && (!busy_ff || reply_end);

      busy_in = busy_ff;
      desc_in = desc_ff;
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      if (pop) begin
         busy_in = 1'b1;
         desc_in = head_data;
         idx_in  = '0;
         crc_in  = crf_pkg::CRC_ONES;
      end else if (reply_end) begin
         busy_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 4'd1;
         if (!in_crc) begin
            crc_in = crf_pkg::crc_byte(crc_ff, pay_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      desc_ff <= desc_in;
      crc_ff  <= crc_in;
   end

endmodule

`default_nettype wire

// ===== hdl/crc32_frame_command_responder_core.sv =====
// ----------------------------------------------------------------------------
// crc32_frame_command_responder_core
// Frame receiver with CRC-32 check that answers start and data commands.
// ----------------------------------------------------------------------------
// Requests, and the front-end CRC loop: a byte per cycle while the queue is not full.
// Reply: first byte valid once the frame's queued descriptor is loaded by the back end.
// Back end: one reply byte per cycle while ready is high (12 bytes start, 9 bytes data).
// The descriptor queue lets QUEUE_DEPTH replies wait while the front keeps taking bytes.
// Synchronous reset clears the frame state, flags, family register and queue.
`default_nettype none

module crc32_frame_command_responder_core #(
   parameter int QUEUE_DEPTH = crf_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   crf_req_if.sink    req_bus,
   crf_rsp_if.source  rsp_bus,
   crf_csr_if.sink    csr_bus
);

   logic                    queue_full, push, pop, head_valid;
   logic [7:0]              family;
   crf_pkg::reply_desc_type push_data, head_data;

   crf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .rx_byte    (req_bus.rx_byte),
      .frame_end  (req_bus.frame_end),
      .csr_valid  (csr_bus.valid),
      .csr_ready  (csr_bus.ready),
      .csr_family (csr_bus.family_id),
      .family     (family),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   crf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   crf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .family         (family),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .tx_byte        (rsp_bus.tx_byte),
      .tx_last        (rsp_bus.tx_last),
      .update_started (rsp_bus.update_started),
      .update_done    (rsp_bus.update_done)
   );

endmodule

`default_nettype wire

// ===== hdl/crf_checker.sv =====
// ----------------------------------------------------------------------------
// crf_checker
// Port-level assertions for the responder core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] tx_byte,
   input logic       tx_last,
   input logic       update_started,
   input logic       update_done
);

   logic seen_started_ff, seen_started_in;
   logic seen_done_ff, seen_done_in;
   logic rsp_fire;

   assign rsp_fire        = rsp_valid && rsp_ready;
   assign seen_started_in = seen_started_ff || (rsp_valid && update_started);
   assign seen_done_in    = seen_done_ff || (rsp_valid && update_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_started_ff <= 1'b0;
         seen_done_ff    <= 1'b0;
      end else begin
         seen_started_ff <= seen_started_in;
         seen_done_ff    <= seen_done_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_byte) && $stable(tx_last))
      else $error("reply byte changed while stalled");

   a_reply_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !tx_last |=> rsp_valid && $stable(update_started) && $stable(update_done))
      else $error("reply broken or flags changed inside a reply");

   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_started_ff |-> update_started)
      else $error("started flag dropped");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_done_ff |-> update_done)
      else $error("done flag dropped");

endmodule

bind crc32_frame_command_responder_core crf_checker u_crf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .tx_byte        (rsp_bus.tx_byte),
   .tx_last        (rsp_bus.tx_last),
   .update_started (rsp_bus.update_started),
   .update_done    (rsp_bus.update_done)
);

`default_nettype wire
